// File: hw/rtl/srht_pkg.sv
// shared types and constants of the service registry hash table
`default_nettype none

package srht_pkg;

   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD      = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_REG_BYTE   = 2'd0,
      CMD_UNREG      = 2'd1,
      CMD_ROUTE_BYTE = 2'd2,
      CMD_DELIVER    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_REG    = 2'd0,
      OP_UNREG  = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_BAD    = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [31:0] handler;
      logic [31:0] user;
   } op_word_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] hash;
      logic [31:0] handler;
      logic [31:0] user;
   } entry_type;

endpackage

`default_nettype wire

// File: hw/rtl/srht_ram.sv
// generic single write port ram with registered read
`default_nettype none

module srht_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/srht_fifo.sv
// short operation queue between front and back
`default_nettype none

module srht_fifo
   import srht_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire op_word_type push_word,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output op_word_type      pop_word
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   op_word_type     slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_word = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/srht_front.sv
// front end: hash accumulation and command classification
`default_nettype none

module srht_front
   import srht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_name_byte,
   input  wire logic        req_last_byte,
   input  wire logic [31:0] req_service_id,
   input  wire logic [31:0] req_target_hash,
   input  wire logic [31:0] req_handler_tag,
   input  wire logic [31:0] req_user_tag,
   output logic             q_push,
   input  wire logic        q_full,
   output op_word_type      q_word
);

   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic        accept;
   cmd_type     cmd;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign cmd      = cmd_type'(req_command);
   assign hash_in  = 32'((hash_ff ^ {24'd0, req_name_byte}) * FNV_PRIME);

   always_comb begin
      q_push         = 1'b0;
      q_word.op      = OP_BAD;
      q_word.key     = '0;
      q_word.handler = req_handler_tag;
      q_word.user    = req_user_tag;
      unique case (cmd)
         CMD_REG_BYTE: begin
            q_push     = accept && req_last_byte;
            q_word.key = hash_in;
            q_word.op  = (req_handler_tag == '0 || hash_in == '0) ? OP_BAD : OP_REG;
         end
         CMD_ROUTE_BYTE: begin
            q_push     = accept && req_last_byte;
            q_word.key = hash_in;
            q_word.op  = (hash_in == '0) ? OP_BAD : OP_LOOKUP;
         end
         CMD_UNREG: begin
            q_push     = accept;
            q_word.key = req_service_id;
            q_word.op  = (req_service_id == '0) ? OP_BAD : OP_UNREG;
         end
         CMD_DELIVER: begin
            q_push     = accept;
            q_word.key = req_target_hash;
            q_word.op  = (req_target_hash == '0) ? OP_BAD : OP_LOOKUP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else if (accept && (cmd == CMD_REG_BYTE || cmd == CMD_ROUTE_BYTE)) begin
         hash_ff <= req_last_byte ? FNV_BASIS : hash_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/srht_back.sv
// back end: table scan, update and result register
`default_nettype none

module srht_back
   import srht_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   output logic             q_pop,
   input  wire op_word_type q_word,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_assigned_id,
   output logic [31:0]      rsp_name_hash,
   output logic [31:0]      rsp_match_handler,
   output logic [31:0]      rsp_match_user
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type          state_ff;
   op_word_type        op_ff;
   logic [CW-1:0]      cnt_ff;
   logic               chk_vld_ff;
   logic [IW-1:0]      chk_idx_ff;
   logic               found_ff;
   logic [IW-1:0]      found_idx_ff;
   logic [31:0]        found_handler_ff;
   logic [31:0]        found_user_ff;
   logic               free_ff;
   logic [IW-1:0]      free_idx_ff;
   logic [TABLE_ENTRIES-1:0] used_ff;
   logic [31:0]        next_id_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [31:0]        rsp_assigned_id_ff;
   logic [31:0]        rsp_name_hash_ff;
   logic [31:0]        rsp_match_handler_ff;
   logic [31:0]        rsp_match_user_ff;

   logic               ram_we;
   entry_type          ram_wentry;
   logic [EW-1:0]      ram_rdata;
   entry_type          rd_entry;
   logic               chk_used;
   logic               key_hit;
   logic               hit;
   logic               out_free;
   logic [31:0]        next_id_inc;

   assign out_free    = !rsp_valid_ff || rsp_pop;
   assign q_pop       = (state_ff == S_IDLE) && !q_empty;
   assign rd_entry    = entry_type'(ram_rdata);
   assign chk_used    = used_ff[chk_idx_ff];
   assign key_hit     = (op_ff.op == OP_UNREG) ? (rd_entry.id == op_ff.key)
                                               : (rd_entry.hash == op_ff.key);
   assign hit         = chk_vld_ff && chk_used && key_hit;
   assign next_id_inc = next_id_ff + 32'd1;

   assign ram_we = (state_ff == S_FINISH) && out_free && (op_ff.op == OP_REG)
                   && !found_ff && free_ff;
   assign ram_wentry.id      = next_id_ff;
   assign ram_wentry.hash    = op_ff.key;
   assign ram_wentry.handler = op_ff.handler;
   assign ram_wentry.user    = op_ff.user;

   srht_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx_ff),
      .wr_data (ram_wentry),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         used_ff      <= '0;
         next_id_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         chk_vld_ff <= 1'b0;
         if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  op_ff    <= q_word;
                  cnt_ff   <= '0;
                  found_ff <= 1'b0;
                  free_ff  <= 1'b0;
                  state_ff <= (q_word.op == OP_BAD) ? S_FINISH : S_SCAN;
               end
            end
            S_SCAN: begin
               if (cnt_ff != CW'(TABLE_ENTRIES)) begin
                  chk_vld_ff <= 1'b1;
                  chk_idx_ff <= cnt_ff[IW-1:0];
                  cnt_ff     <= cnt_ff + 1'b1;
               end else if (!chk_vld_ff) begin
                  state_ff <= S_FINISH;
               end
               if (hit && !found_ff) begin
                  found_ff         <= 1'b1;
                  found_idx_ff     <= chk_idx_ff;
                  found_handler_ff <= rd_entry.handler;
                  found_user_ff    <= rd_entry.user;
               end
               if (chk_vld_ff && !chk_used && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= chk_idx_ff;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_assigned_id_ff   <= '0;
                  rsp_match_handler_ff <= '0;
                  rsp_match_user_ff    <= '0;
                  rsp_name_hash_ff     <= (op_ff.op == OP_UNREG) ? '0 : op_ff.key;
                  unique case (op_ff.op)
                     OP_BAD: begin
                        rsp_status_ff <= ST_BAD;
                     end
                     OP_REG: begin
                        if (found_ff) begin
                           rsp_status_ff <= ST_DUP;
                        end else if (!free_ff) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           rsp_status_ff         <= ST_OK;
                           rsp_assigned_id_ff    <= next_id_ff;
                           used_ff[free_idx_ff]  <= 1'b1;
                           next_id_ff <= (next_id_inc == '0) ? 32'd1 : next_id_inc;
                        end
                     end
                     OP_UNREG: begin
                        if (found_ff) begin
                           rsp_status_ff         <= ST_OK;
                           used_ff[found_idx_ff] <= 1'b0;
                        end else begin
                           rsp_status_ff <= ST_NOTFOUND;
                        end
                     end
                     OP_LOOKUP: begin
                        if (found_ff) begin
                           rsp_status_ff        <= ST_OK;
                           rsp_match_handler_ff <= found_handler_ff;
                           rsp_match_user_ff    <= found_user_ff;
                        end else begin
                           rsp_status_ff <= ST_NOTFOUND;
                        end
                     end
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_id   = rsp_assigned_id_ff;
   assign rsp_name_hash     = rsp_name_hash_ff;
   assign rsp_match_handler = rsp_match_handler_ff;
   assign rsp_match_user    = rsp_match_user_ff;

endmodule

`default_nettype wire

// File: hw/rtl/service_registry_hash_table_core.sv
// Service registry keyed by the FNV-1a hash of a name, streamed one byte per word.
// A name byte that is not the last one is folded into the hash register and
// gives no result. The last name byte, an unregister or a deliver becomes one
// table operation, held in a two-deep queue while the back end works. The back
// end scans the entry RAM one entry per cycle through its single read port; an
// operation rejected for a bad argument (zero handler, zero hash, zero id) skips
// the scan and goes straight to the result. Slot valid bits sit in flip-flops
// and clear at reset, so no clearing pass is needed.
`default_nettype none

module service_registry_hash_table_core
   import srht_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_name_byte,
   input  wire logic        req_last_byte,
   input  wire logic [31:0] req_service_id,
   input  wire logic [31:0] req_target_hash,
   input  wire logic [31:0] req_handler_tag,
   input  wire logic [31:0] req_user_tag,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_assigned_id,
   output logic [31:0]      rsp_name_hash,
   output logic [31:0]      rsp_match_handler,
   output logic [31:0]      rsp_match_user
);

   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_empty;
   op_word_type q_push_word;
   op_word_type q_pop_word;

   srht_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_name_byte   (req_name_byte),
      .req_last_byte   (req_last_byte),
      .req_service_id  (req_service_id),
      .req_target_hash (req_target_hash),
      .req_handler_tag (req_handler_tag),
      .req_user_tag    (req_user_tag),
      .q_push          (q_push),
      .q_full          (q_full),
      .q_word          (q_push_word)
   );

   srht_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_word  (q_pop_word)
   );

   srht_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_word            (q_pop_word),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_status        (rsp_status),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_name_hash     (rsp_name_hash),
      .rsp_match_handler (rsp_match_handler),
      .rsp_match_user    (rsp_match_user)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("operation pushed into a full queue");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |->
         (rsp_assigned_id == '0 && rsp_match_handler == '0 && rsp_match_user == '0))
      else $error("failed result carries nonzero id or tags");

   a_id_on_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_assigned_id != '0) |->
         (rsp_status == ST_OK && rsp_name_hash != '0))
      else $error("id handed out without a successful register");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result pending right after reset");

endmodule

`default_nettype wire
